// ===== src/rvt_pkg.sv =====
// Shared types, constants and the interrupt priority function for the trap entry unit.
// No dependencies; every other file in src imports this package.
package rvt_pkg;

    // request kinds
    localparam logic [1:0] REQ_IRQ    = 2'd0;
    localparam logic [1:0] REQ_EXC    = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;

    // privilege levels
    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd1;
    localparam logic [1:0] PRIV_RSVD    = 2'd2;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    // interrupt cause codes
    localparam logic [3:0] IRQ_SSI = 4'd1;
    localparam logic [3:0] IRQ_MSI = 4'd3;
    localparam logic [3:0] IRQ_STI = 4'd5;
    localparam logic [3:0] IRQ_MTI = 4'd7;
    localparam logic [3:0] IRQ_SEI = 4'd9;
    localparam logic [3:0] IRQ_MEI = 4'd11;
    localparam logic [3:0] IRQ_NONE = 4'd0;

    localparam logic [11:0] STD_IRQ_BITS = 12'hAAA;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_IRQ_ENABLE  = 3'd0;
    localparam logic [2:0] REG_IRQ_DELEG   = 3'd1;
    localparam logic [2:0] REG_EXC_DELEG   = 3'd2;
    localparam logic [2:0] REG_M_VEC_BASE  = 3'd3;
    localparam logic [2:0] REG_M_VECTORED  = 3'd4;
    localparam logic [2:0] REG_S_VEC_BASE  = 3'd5;
    localparam logic [2:0] REG_S_VECTORED  = 3'd6;

    typedef struct packed {
        logic [11:0] irq_enable_mask;
        logic [11:0] irq_delegate_mask;
        logic [15:0] exc_delegate_mask;
        logic [31:0] machine_vector_base;
        logic        machine_vectored;
        logic [31:0] super_vector_base;
        logic        super_vectored;
    } rvt_cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] pending_irqs;
        logic [3:0]  exc_code;
        logic [31:0] current_pc;
        logic [1:0]  set_priv;
        logic        set_m_enable;
        logic        set_s_enable;
    } rvt_item_t;

    typedef struct packed {
        logic        trap_taken;
        logic        to_machine;
        logic        is_interrupt;
        logic [3:0]  cause_code;
        logic [31:0] next_pc;
        logic [1:0]  priv_after;
    } rvt_result_t;

    // outcome of interrupt screening
    typedef struct packed {
        logic       take;
        logic       to_machine;
        logic [3:0] code;
    } rvt_irq_t;

    // fixed priority MEI, MSI, MTI, SEI, SSI, STI
    function automatic logic [3:0] pick_irq(input logic [11:0] set);
        logic [3:0] code;
        if (set[IRQ_MEI])      code = IRQ_MEI;
        else if (set[IRQ_MSI]) code = IRQ_MSI;
        else if (set[IRQ_MTI]) code = IRQ_MTI;
        else if (set[IRQ_SEI]) code = IRQ_SEI;
        else if (set[IRQ_SSI]) code = IRQ_SSI;
        else if (set[IRQ_STI]) code = IRQ_STI;
        else                   code = IRQ_NONE;
        return code;
    endfunction

endpackage

// ===== src/rvt_irq_pick.sv =====
// Interrupt screening: enable and delegation masks, global enables, priority pick.
// Depends on rvt_pkg.
module rvt_irq_pick
    import rvt_pkg::*;
(
    input  logic [11:0] pending,
    input  logic [11:0] enable_mask,
    input  logic [11:0] delegate_mask,
    input  logic [1:0]  priv,
    input  logic        m_ie,
    input  logic        s_ie,
    output rvt_irq_t    sel
);

    logic [11:0] active;
    logic [11:0] m_set;
    logic [11:0] s_set;
    logic        m_ok;
    logic        s_ok;

    assign active = pending & enable_mask & STD_IRQ_BITS;
    assign m_set  = active & ~delegate_mask;
    assign s_set  = active & delegate_mask;

    // machine interrupts always pre-empt lower modes; supervisor ones never reach machine mode
    assign m_ok = (priv != PRIV_MACHINE) || m_ie;
    assign s_ok = (priv == PRIV_USER) || ((priv == PRIV_SUPER) && s_ie);

    always_comb
    begin
        sel = '0;
        if ((m_set != '0) && m_ok)
        begin
            sel.take       = 1'b1;
            sel.to_machine = 1'b1;
            sel.code       = pick_irq(m_set);
        end
        else if ((s_set != '0) && s_ok)
        begin
            sel.take       = 1'b1;
            sel.to_machine = 1'b0;
            sel.code       = pick_irq(s_set);
        end
    end

endmodule

// ===== src/rvt_trap_core.sv =====
// Trap decision and architectural trap state (privilege, enables, saved pc, cause).
// Depends on rvt_pkg and rvt_irq_pick.
module rvt_trap_core
    import rvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  rvt_item_t   item,
    input  rvt_cfg_t    cfg,
    output rvt_result_t res
);

    logic [1:0]  privilege_reg,    privilege_next;
    logic        m_int_enable_reg, m_int_enable_next;
    logic        m_prev_enable_reg, m_prev_enable_next;
    logic [1:0]  m_prev_priv_reg,  m_prev_priv_next;
    logic        s_int_enable_reg, s_int_enable_next;
    logic        s_prev_enable_reg, s_prev_enable_next;
    logic [1:0]  s_prev_priv_reg,  s_prev_priv_next;
    logic [31:0] m_saved_pc_reg,   m_saved_pc_next;
    logic [31:0] s_saved_pc_reg,   s_saved_pc_next;
    logic [4:0]  m_cause_reg,      m_cause_next;
    logic [4:0]  s_cause_reg,      s_cause_next;

    rvt_irq_t    irq;
    logic        exc_to_super;
    logic        trap;
    logic        to_m;
    logic        intr;
    logic [3:0]  code;
    logic [31:0] m_base;
    logic [31:0] s_base;
    logic [31:0] handler;

    rvt_irq_pick u_irq_pick (
        .pending       (item.pending_irqs),
        .enable_mask   (cfg.irq_enable_mask),
        .delegate_mask (cfg.irq_delegate_mask),
        .priv          (privilege_reg),
        .m_ie          (m_int_enable_reg),
        .s_ie          (s_int_enable_reg),
        .sel           (irq)
    );

    assign exc_to_super = (privilege_reg != PRIV_MACHINE) && cfg.exc_delegate_mask[item.exc_code];

    always_comb
    begin
        trap = 1'b0;
        to_m = 1'b0;
        intr = 1'b0;
        code = '0;
        case (item.req_type)
            REQ_IRQ:
            begin
                trap = irq.take;
                to_m = irq.to_machine;
                intr = irq.take;
                code = irq.code;
            end
            REQ_EXC:
            begin
                trap = 1'b1;
                to_m = !exc_to_super;
                code = item.exc_code;
            end
            default:
            begin
                trap = 1'b0;
            end
        endcase
    end

    assign m_base = {cfg.machine_vector_base[31:2], 2'b00};
    assign s_base = {cfg.super_vector_base[31:2], 2'b00};

    // vectored entry only for interrupts: base + 4 * cause, wrapping
    always_comb
    begin
        if (to_m)
            handler = (intr && cfg.machine_vectored) ? m_base + {26'd0, code, 2'b00} : m_base;
        else
            handler = (intr && cfg.super_vectored) ? s_base + {26'd0, code, 2'b00} : s_base;
    end

    always_comb
    begin
        privilege_next     = privilege_reg;
        m_int_enable_next  = m_int_enable_reg;
        m_prev_enable_next = m_prev_enable_reg;
        m_prev_priv_next   = m_prev_priv_reg;
        s_int_enable_next  = s_int_enable_reg;
        s_prev_enable_next = s_prev_enable_reg;
        s_prev_priv_next   = s_prev_priv_reg;
        m_saved_pc_next    = m_saved_pc_reg;
        s_saved_pc_next    = s_saved_pc_reg;
        m_cause_next       = m_cause_reg;
        s_cause_next       = s_cause_reg;
        if (trap && to_m)
        begin
            m_cause_next       = {intr, code};
            m_prev_priv_next   = privilege_reg;
            privilege_next     = PRIV_MACHINE;
            m_prev_enable_next = m_int_enable_reg;
            m_int_enable_next  = 1'b0;
            m_saved_pc_next    = item.current_pc;
        end
        else if (trap)
        begin
            s_cause_next       = {intr, code};
            s_prev_priv_next   = privilege_reg;
            privilege_next     = PRIV_SUPER;
            s_prev_enable_next = s_int_enable_reg;
            s_int_enable_next  = 1'b0;
            s_saved_pc_next    = item.current_pc;
        end
        else if (item.req_type == REQ_STATUS)
        begin
            // reserved level keeps the privilege but still writes the enables
            if (item.set_priv != PRIV_RSVD)
                privilege_next = item.set_priv;
            m_int_enable_next = item.set_m_enable;
            s_int_enable_next = item.set_s_enable;
        end
    end

    always_comb
    begin
        res.trap_taken   = trap;
        res.to_machine   = trap && to_m;
        res.is_interrupt = intr;
        res.cause_code   = trap ? code : 4'd0;
        res.next_pc      = trap ? handler : item.current_pc;
        res.priv_after   = privilege_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            privilege_reg     <= PRIV_MACHINE;
            m_int_enable_reg  <= 1'b0;
            m_prev_enable_reg <= 1'b0;
            m_prev_priv_reg   <= PRIV_USER;
            s_int_enable_reg  <= 1'b0;
            s_prev_enable_reg <= 1'b0;
            s_prev_priv_reg   <= PRIV_USER;
            m_saved_pc_reg    <= '0;
            s_saved_pc_reg    <= '0;
            m_cause_reg       <= '0;
            s_cause_reg       <= '0;
        end
        else if (fire)
        begin
            privilege_reg     <= privilege_next;
            m_int_enable_reg  <= m_int_enable_next;
            m_prev_enable_reg <= m_prev_enable_next;
            m_prev_priv_reg   <= m_prev_priv_next;
            s_int_enable_reg  <= s_int_enable_next;
            s_prev_enable_reg <= s_prev_enable_next;
            s_prev_priv_reg   <= s_prev_priv_next;
            m_saved_pc_reg    <= m_saved_pc_next;
            s_saved_pc_reg    <= s_saved_pc_next;
            m_cause_reg       <= m_cause_next;
            s_cause_reg       <= s_cause_next;
        end
    end

`ifndef SYNTHESIS
    a_m_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.trap_taken && res.to_machine |=>
            privilege_reg == PRIV_MACHINE && !m_int_enable_reg &&
            m_saved_pc_reg == $past(item.current_pc) &&
            m_prev_priv_reg == $past(privilege_reg))
        else $error("machine trap entry did not update machine state");

    a_s_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.trap_taken && !res.to_machine |=>
            privilege_reg == PRIV_SUPER && !s_int_enable_reg &&
            s_saved_pc_reg == $past(item.current_pc) &&
            s_prev_enable_reg == $past(s_int_enable_reg))
        else $error("supervisor trap entry did not update supervisor state");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(privilege_reg) && $stable(m_cause_reg) && $stable(s_cause_reg))
        else $error("trap state changed without an item");

    a_cause_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.trap_taken && res.to_machine |=> m_cause_reg[4] == $past(res.is_interrupt))
        else $error("machine cause interrupt flag mismatch");

    a_no_s_from_m: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.is_interrupt && !res.to_machine |-> privilege_reg != PRIV_MACHINE)
        else $error("supervisor interrupt taken in machine mode");
`endif

endmodule

// ===== src/rv32_trap_entry_unit_core.sv =====
// Top level of the trap entry unit: APB configuration registers, input and result registers.
// Depends on rvt_pkg and rvt_trap_core.
//
// Trap entry unit. Every accepted word is an interrupt check, a synchronous exception or
// a status update, and yields exactly one result word. That result is registered after the word
// leaves the input register, and is held there while the output side is stalled. One word
// is accepted per cycle unless in_stall is high: the trap decision and the update of the
// privilege, enable, saved pc and cause registers happen combinationally between the
// input register and the result register, so the next word always sees the state left by
// the previous one. A stalled output holds the result; the input register is only stalled
// when both registers are full and the output is stalled. Configuration registers sit at
// byte addresses 4 * index and may only be written while no word is in flight.
module rv32_trap_entry_unit_core
    import rvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [11:0] pending_irqs,
    input  logic [3:0]  exc_code,
    input  logic [31:0] current_pc,
    input  logic [1:0]  set_priv,
    input  logic        set_m_enable,
    input  logic        set_s_enable,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        trap_taken,
    output logic        to_machine,
    output logic        is_interrupt,
    output logic [3:0]  cause_code,
    output logic [31:0] next_pc,
    output logic [1:0]  priv_after
);

    rvt_cfg_t    cfg_reg;
    rvt_item_t   item_reg;
    logic        item_valid_reg, item_valid_next;
    rvt_result_t res_reg;
    logic        res_valid_reg, res_valid_next;
    rvt_result_t res;
    logic        advance;
    logic        fire;
    logic        accept;
    logic        cfg_wr;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_IRQ_ENABLE: cfg_reg.irq_enable_mask     <= pwdata[11:0];
                REG_IRQ_DELEG:  cfg_reg.irq_delegate_mask   <= pwdata[11:0];
                REG_EXC_DELEG:  cfg_reg.exc_delegate_mask   <= pwdata[15:0];
                REG_M_VEC_BASE: cfg_reg.machine_vector_base <= pwdata;
                REG_M_VECTORED: cfg_reg.machine_vectored    <= pwdata[0];
                REG_S_VEC_BASE: cfg_reg.super_vector_base   <= pwdata;
                REG_S_VECTORED: cfg_reg.super_vectored      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IRQ_ENABLE: prdata = {20'd0, cfg_reg.irq_enable_mask};
            REG_IRQ_DELEG:  prdata = {20'd0, cfg_reg.irq_delegate_mask};
            REG_EXC_DELEG:  prdata = {16'd0, cfg_reg.exc_delegate_mask};
            REG_M_VEC_BASE: prdata = cfg_reg.machine_vector_base;
            REG_M_VECTORED: prdata = {31'd0, cfg_reg.machine_vectored};
            REG_S_VEC_BASE: prdata = cfg_reg.super_vector_base;
            REG_S_VECTORED: prdata = {31'd0, cfg_reg.super_vectored};
            default:        prdata = '0;
        endcase
    end

    // result register frees up when empty or taken this cycle
    assign advance  = !res_valid_reg || !out_stall;
    assign fire     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign item_valid_next = accept || (item_valid_reg && !advance);
    assign res_valid_next  = fire || (res_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type     <= req_type;
            item_reg.pending_irqs <= pending_irqs;
            item_reg.exc_code     <= exc_code;
            item_reg.current_pc   <= current_pc;
            item_reg.set_priv     <= set_priv;
            item_reg.set_m_enable <= set_m_enable;
            item_reg.set_s_enable <= set_s_enable;
        end
        if (fire)
            res_reg <= res;
    end

    rvt_trap_core u_trap_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_valid    = res_valid_reg;
    assign trap_taken   = res_reg.trap_taken;
    assign to_machine   = res_reg.to_machine;
    assign is_interrupt = res_reg.is_interrupt;
    assign cause_code   = res_reg.cause_code;
    assign next_pc      = res_reg.next_pc;
    assign priv_after   = res_reg.priv_after;

endmodule
